@@ rtl/sbf_pkg.sv @@
// Shared constants and types for the spring / bungee force block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
package sbf_pkg;
	localparam int DATA_W          = 32;   // port width of coordinates and forces
	localparam int CFG_W           = 31;   // width of the two registers
	localparam int CFG_IDX_W       = 1;
	localparam int FRAC_BITS       = 16;
	localparam int QUO_BITS        = 33;   // quotient bits kept before clipping
	localparam int COORD_BITS_DEF  = 32;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 1'b1;

	localparam logic OP_SPRING = 1'b0;
	localparam logic OP_BUNGEE = 1'b1;

	typedef struct packed {
		logic       applied;
		logic       zf;      // all force components forced to zero
		logic [2:0] neg;     // component of d is negative
	} sbf_flags_t;
endpackage

@@ rtl/sbf_in_if.sv @@
// Input channel: valid/ready plus one spring item.
// Depends on sbf_pkg.
`timescale 1ns / 1ps
interface sbf_in_if;
	import sbf_pkg::*;
	logic              valid;
	logic              ready;
	logic              op;
	logic [DATA_W-1:0] pos_x;
	logic [DATA_W-1:0] pos_y;
	logic [DATA_W-1:0] pos_z;
	logic [DATA_W-1:0] other_x;
	logic [DATA_W-1:0] other_y;
	logic [DATA_W-1:0] other_z;
	modport source (output valid, op, pos_x, pos_y, pos_z, other_x, other_y, other_z,
		input ready);
	modport sink (input valid, op, pos_x, pos_y, pos_z, other_x, other_y, other_z,
		output ready);
endinterface

@@ rtl/sbf_out_if.sv @@
// Output channel: valid/ready plus one force result.
// Depends on sbf_pkg.
`timescale 1ns / 1ps
interface sbf_out_if;
	import sbf_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] force_x;
	logic [DATA_W-1:0] force_y;
	logic [DATA_W-1:0] force_z;
	logic              applied;
	logic              saturated;
	modport source (output valid, force_x, force_y, force_z, applied, saturated,
		input ready);
	modport sink (input valid, force_x, force_y, force_z, applied, saturated,
		output ready);
endinterface

@@ rtl/sbf_front.sv @@
// Front end: takes beats, forms d and |d|^2, pipelined bit-per-stage square
// root, then classifies (extension, applied, zero force). Depends on sbf_pkg.
`timescale 1ns / 1ps
module sbf_front #(
	parameter int CW   = sbf_pkg::COORD_BITS_DEF,
	parameter int LW   = CW + 1,
	parameter int EWID = (LW > sbf_pkg::CFG_W) ? LW : sbf_pkg::CFG_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	sbf_in_if.sink                    in_ch,
	input  logic [sbf_pkg::CFG_W-1:0] rest_length,
	input  logic                      push_ok,
	output logic                      fv,
	output sbf_pkg::sbf_flags_t       f_flags,
	output logic [LW-1:0]             f_len,
	output logic [EWID-1:0]           f_e,
	output logic [CW-1:0]             f_ad [3]
);
	import sbf_pkg::*;

	localparam int DW  = CW + 1;
	localparam int SQW = 2 * CW;
	localparam int SW  = 2 * LW;
	localparam int RW  = LW + 2;
	localparam int XW  = LW + CFG_W;

	logic en;
	assign en = !fv || push_ok;
	assign in_ch.ready = en;

	logic signed [CW-1:0] cp [3];
	logic signed [CW-1:0] co [3];
	assign cp[0] = CW'(in_ch.pos_x);
	assign cp[1] = CW'(in_ch.pos_y);
	assign cp[2] = CW'(in_ch.pos_z);
	assign co[0] = CW'(in_ch.other_x);
	assign co[1] = CW'(in_ch.other_y);
	assign co[2] = CW'(in_ch.other_z);

	// s1: difference
	logic                 v_s1, op_s1;
	logic signed [DW-1:0] d_s1 [3];
	// s2: magnitude and sign
	logic                 v_s2, op_s2;
	logic [2:0]           neg_s2;
	logic [CW-1:0]        ad_s2 [3];
	// s3: squares
	logic                 v_s3, op_s3;
	logic [2:0]           neg_s3;
	logic [CW-1:0]        ad_s3 [3];
	logic [SQW-1:0]       sq_s3 [3];

	// square root stages; index 0 holds the summed square
	logic          rv_q   [0:LW];
	logic          rop_q  [0:LW];
	logic [2:0]    rneg_q [0:LW];
	logic [CW-1:0] rad_q  [0:LW][3];
	logic [SW-1:0] rsum_q [0:LW];
	logic [LW-1:0] root_q [0:LW];
	logic [RW-1:0] rem_q  [0:LW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			rv_q[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			rv_q[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= in_ch.op;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
			neg_s3 <= neg_s2;
			rop_q[0] <= op_s3;
			rneg_q[0] <= neg_s3;
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DW'(cp[i]) - DW'(co[i]);
				neg_s2[i] <= d_s1[i][DW-1];
				ad_s2[i] <= d_s1[i][DW-1] ? CW'(-d_s1[i]) : CW'(d_s1[i]);
				ad_s3[i] <= ad_s2[i];
				sq_s3[i] <= SQW'(ad_s2[i]) * SQW'(ad_s2[i]);
				rad_q[0][i] <= ad_s3[i];
			end
			rsum_q[0] <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]);
			root_q[0] <= '0;
			rem_q[0] <= '0;
		end
	end

	for (genvar k = 0; k < LW; k++) begin : g_sqrt
		logic [RW-1:0] rsh, trial;
		assign rsh   = {rem_q[k][RW-3:0], rsum_q[k][SW-1:SW-2]};
		assign trial = {root_q[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_q[k+1] <= 1'b0;
			end else if (en) begin
				rv_q[k+1] <= rv_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rop_q[k+1]  <= rop_q[k];
				rneg_q[k+1] <= rneg_q[k];
				rad_q[k+1]  <= rad_q[k];
				rsum_q[k+1] <= {rsum_q[k][SW-3:0], 2'b00};
				if (rsh >= trial) begin
					rem_q[k+1]  <= rsh - trial;
					root_q[k+1] <= {root_q[k][LW-2:0], 1'b1};
				end else begin
					rem_q[k+1]  <= rsh;
					root_q[k+1] <= {root_q[k][LW-2:0], 1'b0};
				end
			end
		end
	end

	// classify
	logic [XW-1:0] len_x, rest_x;
	logic          slack;
	assign len_x  = XW'(root_q[LW]);
	assign rest_x = XW'(rest_length);
	assign slack  = len_x <= rest_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv <= 1'b0;
		end else if (en) begin
			fv <= rv_q[LW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_len <= root_q[LW];
			f_ad  <= rad_q[LW];
			f_e   <= slack ? EWID'(rest_x - len_x) : EWID'(len_x - rest_x);
			f_flags.neg     <= rneg_q[LW];
			f_flags.applied <= !(rop_q[LW] == OP_BUNGEE && slack);
			f_flags.zf      <= (rop_q[LW] == OP_BUNGEE && slack) || root_q[LW] == '0;
		end
	end
endmodule

@@ rtl/sbf_queue.sv @@
// Small FIFO between front and back end.
// Depends on sbf_pkg.
`timescale 1ns / 1ps
module sbf_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         nempty
);
	import sbf_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full   = cnt_q == (AW+1)'(QUEUE_DEPTH);
	assign nempty = cnt_q != '0;
	assign rdata  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

@@ rtl/sbf_back.sv @@
// Back end: magnitude m = e*k, per-axis m*|d_i|, pipelined divide by L,
// clipping and the output register. Depends on sbf_pkg.
`timescale 1ns / 1ps
module sbf_back #(
	parameter int CW   = sbf_pkg::COORD_BITS_DEF,
	parameter int LW   = CW + 1,
	parameter int EWID = (LW > sbf_pkg::CFG_W) ? LW : sbf_pkg::CFG_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      pop,
	input  sbf_pkg::sbf_flags_t       q_flags,
	input  logic [LW-1:0]             q_len,
	input  logic [EWID-1:0]           q_e,
	input  logic [CW-1:0]             q_ad [3],
	input  logic [sbf_pkg::CFG_W-1:0] stiffness,
	sbf_out_if.source                 out_ch
);
	import sbf_pkg::*;

	localparam int PW  = EWID + CFG_W;
	localparam int MW  = PW - FRAC_BITS;
	localparam int HMW = MW - FRAC_BITS;
	localparam int NW  = MW + CW;
	localparam int HW  = NW - QUO_BITS;
	localparam int XW  = (HW > LW) ? HW : LW;
	localparam int ND  = QUO_BITS;

	logic en;
	assign en  = !out_ch.valid || out_ch.ready;
	assign pop = en && q_valid;

	logic       v_b1, v_b2, v_b3;
	sbf_flags_t fl_b1, fl_b2, fl_b3;
	logic [LW-1:0] len_b1, len_b2, len_b3;
	logic [CW-1:0] ad_b1 [3];
	logic [CW-1:0] ad_b2 [3];
	logic [CW-1:0] ad_b3 [3];
	logic [PW-1:0] prod_b1;
	logic [MW-1:0] m_b1;
	logic [FRAC_BITS+CW-1:0] plo_b2 [3];
	logic [HMW+CW-1:0]       phi_b2 [3];
	logic [NW-1:0]           num_b3 [3];

	assign m_b1 = prod_b1[PW-1:FRAC_BITS];

	// divider stages; index 0 is the setup stage
	logic                dv_q   [0:ND];
	sbf_flags_t          dfl_q  [0:ND];
	logic [LW-1:0]       dlen_q [0:ND];
	logic [2:0]          dnz_q  [0:ND];
	logic [2:0]          dovf_q [0:ND];
	logic [LW-1:0]       drem_q [0:ND][3];
	logic [ND-1:0]       dlo_q  [0:ND][3];
	logic [ND-1:0]       dq_q   [0:ND][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			dv_q[0] <= 1'b0;
		end else if (en) begin
			v_b1 <= q_valid;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			dv_q[0] <= v_b3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_b1  <= q_flags;
			fl_b2  <= fl_b1;
			fl_b3  <= fl_b2;
			len_b1 <= q_len;
			len_b2 <= len_b1;
			len_b3 <= len_b2;
			prod_b1 <= PW'(q_e) * PW'(stiffness);
			dfl_q[0]  <= fl_b3;
			dlen_q[0] <= len_b3;
			for (int i = 0; i < 3; i++) begin
				ad_b1[i]  <= q_ad[i];
				ad_b2[i]  <= ad_b1[i];
				ad_b3[i]  <= ad_b2[i];
				plo_b2[i] <= (FRAC_BITS+CW)'(m_b1[FRAC_BITS-1:0]) * (FRAC_BITS+CW)'(ad_b1[i]);
				phi_b2[i] <= (HMW+CW)'(m_b1[MW-1:FRAC_BITS]) * (HMW+CW)'(ad_b1[i]);
				num_b3[i] <= (NW'(phi_b2[i]) << FRAC_BITS) + NW'(plo_b2[i]);
				// quotient of 2^33 or more clips whatever the sign
				dovf_q[0][i] <= XW'(num_b3[i][NW-1:ND]) >= XW'(len_b3);
				dnz_q[0][i]  <= ad_b3[i] != '0;
				drem_q[0][i] <= LW'(num_b3[i][NW-1:ND]);
				dlo_q[0][i]  <= num_b3[i][ND-1:0];
				dq_q[0][i]   <= '0;
			end
		end
	end

	for (genvar j = 0; j < ND; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_q[j+1] <= 1'b0;
			end else if (en) begin
				dv_q[j+1] <= dv_q[j];
			end
		end

		for (genvar i = 0; i < 3; i++) begin : g_ax
			logic [LW:0] rsh;
			assign rsh = {drem_q[j][i], dlo_q[j][i][ND-1]};
			always_ff @(posedge clk) begin
				if (en) begin
					dlo_q[j+1][i] <= {dlo_q[j][i][ND-2:0], 1'b0};
					if (rsh >= {1'b0, dlen_q[j]}) begin
						drem_q[j+1][i] <= LW'(rsh - {1'b0, dlen_q[j]});
						dq_q[j+1][i]   <= {dq_q[j][i][ND-2:0], 1'b1};
					end else begin
						drem_q[j+1][i] <= LW'(rsh);
						dq_q[j+1][i]   <= {dq_q[j][i][ND-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dfl_q[j+1]  <= dfl_q[j];
				dlen_q[j+1] <= dlen_q[j];
				dnz_q[j+1]  <= dnz_q[j];
				dovf_q[j+1] <= dovf_q[j];
			end
		end
	end

	// clipping: force opposes d, so positive d gives a negative component
	logic [DATA_W-1:0] fc [3];
	logic [2:0]        sc;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fc[i] = '0;
			sc[i] = 1'b0;
			if (!dfl_q[ND].zf && dnz_q[ND][i]) begin
				if (!dfl_q[ND].neg[i]) begin
					if (dovf_q[ND][i] || dq_q[ND][i] > ND'(33'h080000000)) begin
						fc[i] = 32'h80000000;
						sc[i] = 1'b1;
					end else begin
						fc[i] = DATA_W'(0) - DATA_W'(dq_q[ND][i]);
					end
				end else begin
					if (dovf_q[ND][i] || dq_q[ND][i] > ND'(33'h07FFFFFFF)) begin
						fc[i] = 32'h7FFFFFFF;
						sc[i] = 1'b1;
					end else begin
						fc[i] = DATA_W'(dq_q[ND][i]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (en) begin
			out_ch.valid <= dv_q[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.force_x   <= fc[0];
			out_ch.force_y   <= fc[1];
			out_ch.force_z   <= fc[2];
			out_ch.applied   <= dfl_q[ND].applied;
			out_ch.saturated <= |sc;
		end
	end
endmodule

@@ rtl/spring_bungee_force.sv @@
// Spring / bungee force, top level.
// One beat in on in_ch carries a mode and two 3D points in Q16.16; one beat
// out on out_ch carries the force on the particle, applied and saturated.
// rest_length and stiffness are written through cfg_we / cfg_index /
// cfg_data; the user must write them only while the block is idle (the
// block itself does not enforce this). Both reset to 1.0. A beat passes
// through the front end, the 4-entry queue and the back end. Throughput:
// one beat per cycle in each direction while out_ch.ready stays high. The
// length comes from a bit-per-stage square root pipeline and each axis has
// its own bit-per-stage divider, so nothing is shared between items.
// When the receiver stalls, the back end holds its result in the output
// register and the front end keeps taking beats until the queue is full and
// a result waits at its output; in_ch.ready then drops. Reset empties the
// pipeline and the queue and restores both registers.
// Depends on sbf_pkg, sbf_in_if, sbf_out_if, sbf_front, sbf_queue, sbf_back.
`timescale 1ns / 1ps
module spring_bungee_force #(
	parameter int COORD_BITS = sbf_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sbf_in_if.sink                        in_ch,
	sbf_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [sbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbf_pkg::CFG_W-1:0]     cfg_data
);
	import sbf_pkg::*;

	localparam int CW   = COORD_BITS;
	localparam int LW   = CW + 1;
	localparam int EWID = (LW > CFG_W) ? LW : CFG_W;
	localparam int FLW  = $bits(sbf_flags_t);
	localparam int QW   = FLW + LW + EWID + 3 * CW;

	logic [CFG_W-1:0] rest_q, stiff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q  <= CFG_W'(32'h00010000);
			stiff_q <= CFG_W'(32'h00010000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REST_LENGTH: rest_q  <= cfg_data;
				REG_STIFFNESS:   stiff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic            fv, q_full, q_nempty, q_pop, q_push;
	sbf_flags_t      f_flags, q_flags;
	logic [LW-1:0]   f_len, q_len;
	logic [EWID-1:0] f_e, q_e;
	logic [CW-1:0]   f_ad [3];
	logic [CW-1:0]   q_ad [3];
	logic [QW-1:0]   q_wdata, q_rdata;

	sbf_front #(.CW(CW), .LW(LW), .EWID(EWID)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.rest_length (rest_q),
		.push_ok     (!q_full),
		.fv          (fv),
		.f_flags     (f_flags),
		.f_len       (f_len),
		.f_e         (f_e),
		.f_ad        (f_ad)
	);

	assign q_push  = fv && !q_full;
	assign q_wdata = {f_flags, f_len, f_e, f_ad[2], f_ad[1], f_ad[0]};
	assign {q_flags, q_len, q_e, q_ad[2], q_ad[1], q_ad[0]} = q_rdata;

	sbf_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.nempty (q_nempty)
	);

	sbf_back #(.CW(CW), .LW(LW), .EWID(EWID)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_nempty),
		.pop       (q_pop),
		.q_flags   (q_flags),
		.q_len     (q_len),
		.q_e       (q_e),
		.q_ad      (q_ad),
		.stiffness (stiff_q),
		.out_ch    (out_ch)
	);
endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for spring_bungee_force: directed and random points,
// several register settings.
// Depends on sbf_pkg, sbf_in_if, sbf_out_if and the block itself.
`timescale 1ns / 1ps

module tb_top;
	import sbf_pkg::*;

	typedef struct {
		logic              op;
		logic [DATA_W-1:0] p [3];
		logic [DATA_W-1:0] o [3];
	} spring_item_t;

	typedef struct {
		logic [DATA_W-1:0] f [3];
		logic              applied;
		logic              saturated;
	} force_res_t;

	class force_scoreboard;
		force_res_t   pending_forces[$];
		logic [127:0] rest_len;
		logic [127:0] k_coef;
		int           errors;

		function new();
			rest_len = 65536;
			k_coef   = 65536;
			errors   = 0;
		endfunction

		function void report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endfunction

		function logic [63:0] isqrt(logic [127:0] s);
			logic [63:0] r;
			logic [63:0] c;
			r = 0;
			for (int b = 63; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if ({64'd0, c} * {64'd0, c} <= s)
					r = c;
			end
			return r;
		endfunction

		// Work out the force for one accepted beat and queue it.
		function void note_input(spring_item_t it);
			longint       d [3];
			logic [127:0] ad [3];
			logic [127:0] sq, len, e, m, q, mag;
			force_res_t   r;
			sq = 0;
			for (int i = 0; i < 3; i++) begin
				d[i]  = longint'($signed(it.p[i])) - longint'($signed(it.o[i]));
				ad[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
				sq    = sq + ad[i] * ad[i];
				r.f[i] = 0;
			end
			r.applied   = 1'b0;
			r.saturated = 1'b0;
			len = {64'd0, isqrt(sq)};
			if (it.op == OP_BUNGEE && len <= rest_len) begin
				pending_forces.push_back(r);
				return;
			end
			e = len >= rest_len ? len - rest_len : rest_len - len;
			r.applied = 1'b1;
			if (len != 0) begin
				m = (e * k_coef) >> FRAC_BITS;
				for (int i = 0; i < 3; i++) begin
					if (d[i] == 0)
						continue;
					q = (m * ad[i]) / len;
					if (d[i] > 0) begin
						if (q > 128'h8000_0000) begin
							mag = 128'h8000_0000;
							r.saturated = 1'b1;
						end else
							mag = q;
						r.f[i] = 32'(-mag[32:0]);
					end else begin
						if (q > 128'h7FFF_FFFF) begin
							mag = 128'h7FFF_FFFF;
							r.saturated = 1'b1;
						end else
							mag = q;
						r.f[i] = mag[31:0];
					end
				end
			end
			pending_forces.push_back(r);
		endfunction

		function void check(force_res_t got);
			force_res_t want;
			if (pending_forces.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			want = pending_forces.pop_front();
			for (int i = 0; i < 3; i++)
				if (got.f[i] !== want.f[i])
					report($sformatf("force[%0d] got %h want %h", i, got.f[i], want.f[i]));
			if (got.applied !== want.applied)
				report($sformatf("applied got %b want %b", got.applied, want.applied));
			if (got.saturated !== want.saturated)
				report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 calm;
	logic                 hold_off;

	sbf_in_if  in_ch();
	sbf_out_if out_ch();

	force_scoreboard sb = new();

	spring_bungee_force DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("spring_bungee_force verification failed");
		$finish;
	end

	// Receiver: random stalls unless calm, plus the long hold-off.
	initial begin
		out_ch.ready = 1'b0;
		forever @(posedge clk) begin
			if (out_ch.valid && out_ch.ready)
				sb.check('{f: '{out_ch.force_x, out_ch.force_y, out_ch.force_z},
					applied: out_ch.applied, saturated: out_ch.saturated});
			out_ch.ready <= arst_n && !hold_off && (calm || $urandom_range(99) >= 11);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_REST_LENGTH)
			sb.rest_len = val;
		else
			sb.k_coef = val;
	endtask

	task automatic drain();
		// the last beat must not be offered again while waiting
		in_ch.valid <= 1'b0;
		while (sb.pending_forces.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic send_beat(spring_item_t it);
		if (!calm && $urandom_range(99) < 11) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.op      <= it.op;
		in_ch.pos_x   <= it.p[0];
		in_ch.pos_y   <= it.p[1];
		in_ch.pos_z   <= it.p[2];
		in_ch.other_x <= it.o[0];
		in_ch.other_y <= it.o[1];
		in_ch.other_z <= it.o[2];
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_input(it);
	endtask

	task automatic send_pts(logic op, logic [31:0] px, py, pz, ox, oy, oz);
		spring_item_t it;
		it.op = op;
		it.p  = '{px, py, pz};
		it.o  = '{ox, oy, oz};
		send_beat(it);
	endtask

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic spring_item_t rand_item();
		spring_item_t it;
		int           kind;
		int           ax;
		kind  = $urandom_range(9);
		it.op = $urandom_range(1);
		for (int i = 0; i < 3; i++) begin
			it.o[i] = $urandom;
			it.p[i] = $urandom;
		end
		case (kind)
			2, 3, 4, 5: begin
				// short springs (each component of d within +/-4.0 in Q16.16), near the 1.0 and 5.0 rest lengths
				for (int i = 0; i < 3; i++) begin
					it.o[i] = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
					it.p[i] = it.o[i] + ($signed($urandom_range(0, 1 << 19)) - (1 << 18));
				end
			end
			6: it.p = it.o;
			7: begin
				ax = $urandom_range(2);
				for (int i = 0; i < 3; i++)
					if (i != ax)
						it.p[i] = it.o[i];
			end
			8, 9: begin
				for (int i = 0; i < 3; i++) begin
					it.o[i] = pick_extreme();
					it.p[i] = pick_extreme();
				end
			end
			default: ;
		endcase
		return it;
	endfunction

	initial begin
		logic [CFG_W-1:0] rests [5];
		logic [CFG_W-1:0] ks [5];
		arst_n        = 1'b0;
		calm          = 1'b0;
		hold_off      = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_REST_LENGTH;
		cfg_data      = '0;
		in_ch.valid   = 1'b0;
		in_ch.op      = OP_SPRING;
		in_ch.pos_x   = '0;
		in_ch.pos_y   = '0;
		in_ch.pos_z   = '0;
		in_ch.other_x = '0;
		in_ch.other_y = '0;
		in_ch.other_z = '0;
		rests = '{65536, 0, 31'h7FFF_FFFF, 5 << 16, $urandom};
		ks    = '{65536, 31'h7FFF_FFFF, 0, 3 << 16, $urandom};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: zero length, slack, stretch, push, extremes, single axes
		send_pts(OP_SPRING, 0, 0, 0, 0, 0, 0);
		send_pts(OP_BUNGEE, 0, 0, 0, 0, 0, 0);
		send_pts(OP_SPRING, 32'h1_0000, 0, 0, 0, 0, 0);
		send_pts(OP_BUNGEE, 32'h1_0000, 0, 0, 0, 0, 0);
		send_pts(OP_BUNGEE, 32'h8000, 0, 0, 0, 0, 0);
		send_pts(OP_SPRING, 32'h8000, 0, 0, 0, 0, 0);
		send_pts(OP_BUNGEE, 32'h3_0000, 0, 0, 0, 0, 0);
		send_pts(OP_SPRING, 0, 32'hFFFD_0000, 0, 0, 0, 0);
		send_pts(OP_BUNGEE, 0, 0, 32'h2_0000, 0, 0, 32'hFFFF_0000);
		send_pts(OP_SPRING, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pts(OP_BUNGEE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pts(OP_SPRING, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF);
		send_pts(OP_BUNGEE, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0);
		send_pts(OP_SPRING, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
		send_pts(OP_SPRING, 1, 1, 1, 0, 0, 0);
		send_pts(OP_BUNGEE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				drain();
				write_reg(REG_REST_LENGTH, rests[ph]);
				write_reg(REG_STIFFNESS, ks[ph]);
			end
			calm = (ph == 2);
			if (ph == 1)
				fork
					begin
						repeat (50) @(posedge clk);
						hold_off = 1'b1;
						repeat (400) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			for (int n = 0; n < 250; n++)
				send_beat(rand_item());
		end
		in_ch.valid <= 1'b0;
		drain();
		if (sb.pending_forces.size() != 0)
			sb.report("results still outstanding at end");
		if (sb.errors == 0)
			$display("spring_bungee_force verification clean");
		else
			$display("spring_bungee_force verification failed");
		$finish;
	end
endmodule
